@@ design/free_cell_sparse_set_core_defines.svh @@
// Assertion macros used by the free cell set core.
`ifndef FREE_CELL_SPARSE_SET_CORE_DEFINES_SVH
`define FREE_CELL_SPARSE_SET_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/fcss_pkg.sv @@
`default_nettype none

package fcss_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int COORD_W   = 7;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 3;
	localparam int RAND_W    = 16;
	localparam int FCOUNT_W  = 13;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_OCCUPY  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PICK    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREE     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd4;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [COORD_W-1:0] SIZE_RESET = 7'd64;

endpackage

`default_nettype wire

@@ design/free_cell_sparse_set_core.sv @@
// Free cell set of a grid: a dense list of free cells plus a per-cell slot map.
// Input stream (s_tvalid/s_tready/s_tdata) carries one command per transaction:
// init, occupy, release, query or pick. Every command yields exactly one result
// transaction on the output stream (m_tvalid/m_tready/m_tdata).
// One command is worked on at a time; s_tready is high only while the core waits
// for a command, and a command may be accepted while the previous result still
// waits in the output register.
// Occupy, release and query read the map, check it and go to the finish state;
// an occupy that moves the last list entry adds a fix step. Unused modes and an
// empty pick go straight to finish; pick divides, one remainder bit per cycle over
// the 16-bit random value, then reads the list; init walks every map entry once.
// Both stores are single-port-write memories with a registered read, and the
// read-then-write of the map sets the steps of occupy.
// After reset the core sweeps the map once to mark every cell occupied, with
// s_tready low during the sweep; configuration writes are taken at any time and
// should be issued only while the core is idle.
// A stalled receiver holds the result in the output register; the core then
// finishes at most one more command and waits with s_tready low.
`default_nettype none
`include "free_cell_sparse_set_core_defines.svh"

module free_cell_sparse_set_core #(
	parameter int MAX_ROWS = fcss_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = fcss_pkg::MAX_COLS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// mode[2:0], cell_row[9:3], cell_col[16:10], rand_value[32:17], zero fill
	input  wire logic [fcss_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// status[2:0], cell_free[3], pick_row[10:4], pick_col[17:11],
	// free_count[30:18], zero fill
	output logic [fcss_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [fcss_pkg::COORD_W-1:0]     cfg_wdata
);
	import fcss_pkg::*;

	localparam int CELLS   = MAX_ROWS * MAX_COLS;
	localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int COUNT_W = $clog2(CELLS + 1);
	localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int PROD_W  = COORD_W + $clog2(MAX_COLS + 1) + 1;
	localparam int MAP_W   = CELL_W + 1;
	localparam int LIST_W  = 2 * COORD_W;
	localparam int CNT_W   = $clog2(RAND_W);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SWEEP = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_FIX   = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_PRD   = 4'd6;
	localparam logic [3:0] S_PICK  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0]          state_q;
	logic [COORD_W-1:0]  rows_q, cols_q, eff_rows, eff_cols;

	// Stores: slot map with a valid bit per cell, and the dense list of cells.
	logic [MAP_W-1:0]    map_mem [CELLS];
	logic [LIST_W-1:0]   list_mem [CELLS];
	logic [MAP_W-1:0]    map_rd_q;
	logic [LIST_W-1:0]   list_rd_q;
	logic                map_we, list_we;
	logic [CELL_W-1:0]   map_waddr, list_waddr, list_raddr;
	logic [MAP_W-1:0]    map_wdata;
	logic [LIST_W-1:0]   list_wdata;

	logic [COUNT_W-1:0]  free_total_q;
	logic [MODE_W-1:0]   mode_q;
	logic [COORD_W-1:0]  row_q, col_q;
	logic [RAND_W-1:0]   dvd_q;
	logic [CELL_W-1:0]   addr_q, last_q, fix_addr_q, fix_slot_q;
	logic                inside_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]    div_cnt_q;

	logic                clr_q;
	logic [CELL_W-1:0]   sw_addr_q;
	logic [RIDX_W-1:0]   sw_row_q;
	logic [CIDX_W-1:0]   sw_col_q;

	logic [STATUS_W-1:0] res_status_q, out_status_q;
	logic                res_free_q, out_free_q;
	logic [COORD_W-1:0]  res_prow_q, res_pcol_q, out_prow_q, out_pcol_q;
	logic [FCOUNT_W-1:0] out_fcount_q;
	logic                m_tvalid_q;

	logic [MODE_W-1:0]   in_mode;
	logic [COORD_W-1:0]  in_row, in_col;
	logic [RAND_W-1:0]   in_rand;
	logic                in_inside;
	logic [CELL_W-1:0]   in_addr, mv_addr;
	logic [PROD_W-1:0]   in_prod, mv_prod;
	logic                accept;
	logic                sw_interior, sw_last;
	logic [COUNT_W:0]    rem_shift;
	logic [COUNT_W-1:0]  rem_next;
	logic                map_hit;
	logic [CELL_W-1:0]   map_slot;
	logic [COORD_W-1:0]  mv_row, mv_col;

	assign in_mode = s_tdata[2:0];
	assign in_row  = s_tdata[9:3];
	assign in_col  = s_tdata[16:10];
	assign in_rand = s_tdata[32:17];

	assign eff_rows = ({2'b00, rows_q} > 9'(MAX_ROWS)) ? COORD_W'(MAX_ROWS) : rows_q;
	assign eff_cols = ({2'b00, cols_q} > 9'(MAX_COLS)) ? COORD_W'(MAX_COLS) : cols_q;

	assign in_inside = (in_row != '0) && (in_row <= eff_rows) &&
		(in_col != '0) && (in_col <= eff_cols);
	assign in_prod = PROD_W'(in_row - 7'd1) * PROD_W'(MAX_COLS) + PROD_W'(in_col - 7'd1);
	assign in_addr = CELL_W'(in_prod);

	// Cell that moves into the freed slot when an occupy removes a middle entry.
	assign mv_row  = list_rd_q[COORD_W-1:0];
	assign mv_col  = list_rd_q[LIST_W-1:COORD_W];
	assign mv_prod = PROD_W'(mv_row - 7'd1) * PROD_W'(MAX_COLS) + PROD_W'(mv_col - 7'd1);
	assign mv_addr = CELL_W'(mv_prod);

	assign map_hit  = map_rd_q[CELL_W];
	assign map_slot = map_rd_q[CELL_W-1:0];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign sw_interior = !clr_q && ({1'b0, 8'(sw_row_q)} < 9'(eff_rows)) &&
		({1'b0, 8'(sw_col_q)} < 9'(eff_cols));
	assign sw_last = (sw_addr_q == CELL_W'(CELLS - 1));

	assign rem_shift = {rem_q, dvd_q[RAND_W-1]};
	assign rem_next  = (rem_shift >= {1'b0, free_total_q}) ?
		COUNT_W'(rem_shift - {1'b0, free_total_q}) : COUNT_W'(rem_shift);

	assign list_raddr = (state_q == S_PRD) ? rem_q[CELL_W-1:0] : last_q;

	always_comb begin
		map_we     = 1'b0;
		map_waddr  = addr_q;
		map_wdata  = '0;
		list_we    = 1'b0;
		list_waddr = map_slot;
		list_wdata = list_rd_q;
		unique case (state_q)
			S_SWEEP: begin
				map_we     = 1'b1;
				map_waddr  = sw_addr_q;
				map_wdata  = {sw_interior, CELL_W'(free_total_q)};
				list_we    = sw_interior;
				list_waddr = CELL_W'(free_total_q);
				list_wdata = {COORD_W'(sw_col_q) + 7'd1, COORD_W'(sw_row_q) + 7'd1};
			end
			S_CHK: begin
				if (inside_q) begin
					if (mode_q == MODE_OCCUPY && map_hit) begin
						map_we  = 1'b1;
						list_we = (map_slot != last_q);
					end else if (mode_q == MODE_RELEASE && !map_hit &&
						free_total_q < COUNT_W'(CELLS)) begin
						map_we     = 1'b1;
						map_wdata  = {1'b1, CELL_W'(free_total_q)};
						list_we    = 1'b1;
						list_waddr = CELL_W'(free_total_q);
						list_wdata = {col_q, row_q};
					end
				end
			end
			S_FIX: begin
				map_we    = 1'b1;
				map_waddr = fix_addr_q;
				map_wdata = {1'b1, fix_slot_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		list_rd_q <= list_mem[list_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_RESET;
			cols_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_wdata;
				REG_COLS: cols_q <= cfg_wdata;
				default:  rows_q <= rows_q;
			endcase
		end
	end

	// Payload registers of the current command.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_mode;
			row_q    <= in_row;
			col_q    <= in_col;
			inside_q <= in_inside;
			addr_q   <= in_addr;
			last_q   <= CELL_W'(free_total_q - 1'b1);
		end
		if (state_q == S_CHK) begin
			fix_addr_q <= mv_addr;
			fix_slot_q <= map_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			clr_q        <= 1'b1;
			sw_addr_q    <= '0;
			sw_row_q     <= '0;
			sw_col_q     <= '0;
			free_total_q <= '0;
			rem_q        <= '0;
			dvd_q        <= '0;
			div_cnt_q    <= '0;
			res_status_q <= ST_OK;
			res_free_q   <= 1'b0;
			res_prow_q   <= '0;
			res_pcol_q   <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= ST_OK;
			out_free_q   <= 1'b0;
			out_prow_q   <= '0;
			out_pcol_q   <= '0;
			out_fcount_q <= '0;
		end else begin
			// In the finish state the output register is handled below.
			if (m_tvalid_q && m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_free_q   <= 1'b0;
						res_prow_q   <= '0;
						res_pcol_q   <= '0;
						dvd_q        <= in_rand;
						rem_q        <= '0;
						div_cnt_q    <= CNT_W'(RAND_W - 1);
						priority if (in_mode == MODE_INIT) begin
							state_q      <= S_SWEEP;
							clr_q        <= 1'b0;
							sw_addr_q    <= '0;
							sw_row_q     <= '0;
							sw_col_q     <= '0;
							free_total_q <= '0;
						end else if (in_mode == MODE_OCCUPY || in_mode == MODE_RELEASE ||
							in_mode == MODE_QUERY) begin
							state_q <= S_RD;
						end else if (in_mode == MODE_PICK) begin
							if (free_total_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SWEEP: begin
					if (sw_interior) begin
						free_total_q <= free_total_q + 1'b1;
					end
					sw_addr_q <= sw_addr_q + 1'b1;
					if (sw_col_q == CIDX_W'(MAX_COLS - 1)) begin
						sw_col_q <= '0;
						sw_row_q <= sw_row_q + 1'b1;
					end else begin
						sw_col_q <= sw_col_q + 1'b1;
					end
					if (sw_last) begin
						clr_q   <= 1'b0;
						state_q <= clr_q ? S_IDLE : S_FIN;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= S_FIN;
					priority if (!inside_q) begin
						res_status_q <= ST_OUTSIDE;
					end else if (mode_q == MODE_OCCUPY) begin
						if (!map_hit) begin
							res_status_q <= ST_OCCUPIED;
						end else begin
							free_total_q <= free_total_q - 1'b1;
							if (map_slot != last_q) begin
								state_q <= S_FIX;
							end
						end
					end else if (mode_q == MODE_RELEASE) begin
						if (map_hit) begin
							res_status_q <= ST_FREE;
						end else if (free_total_q < COUNT_W'(CELLS)) begin
							free_total_q <= free_total_q + 1'b1;
						end
					end else begin
						res_free_q <= map_hit;
					end
				end
				S_FIX: begin
					state_q <= S_FIN;
				end
				S_DIV: begin
					rem_q     <= rem_next;
					dvd_q     <= {dvd_q[RAND_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					res_prow_q <= list_rd_q[COORD_W-1:0];
					res_pcol_q <= list_rd_q[LIST_W-1:COORD_W];
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_free_q   <= res_free_q;
						out_prow_q   <= res_prow_q;
						out_pcol_q   <= res_pcol_q;
						out_fcount_q <= FCOUNT_W'(free_total_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_fcount_q, out_pcol_q, out_prow_q, out_free_q, out_status_q};

	`FCSS_ASSERT_NOW(a_result_from_fin, clk, arst_n, $rose(m_tvalid_q), $past(state_q) == S_FIN, "result appeared outside the finish state")
	`FCSS_ASSERT_NEXT(a_occupy_drops_one, clk, arst_n, (state_q == S_CHK) && inside_q && (mode_q == MODE_OCCUPY) && map_hit, free_total_q == $past(free_total_q) - 1'b1, "occupy did not remove exactly one cell")
	`FCSS_ASSERT_NEXT(a_release_adds_one, clk, arst_n, (state_q == S_CHK) && inside_q && (mode_q == MODE_RELEASE) && !map_hit && (free_total_q < COUNT_W'(CELLS)), free_total_q == $past(free_total_q) + 1'b1, "release did not add exactly one cell")
	`FCSS_ASSERT_NOW(a_divisor_nonzero, clk, arst_n, (state_q == S_DIV) || (state_q == S_PRD), free_total_q != '0, "pick reduction with an empty set")

endmodule

`default_nettype wire
